// File: rtl/pla_pkg.sv
// Shared types and codes for the priority lamp effect allocator.
package pla_pkg;

  // Request kinds carried on in_tuser
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_RESTART = 3'd2;
  localparam logic [2:0] KIND_EXIT    = 3'd3;
  localparam logic [2:0] KIND_QALLOC  = 3'd4;
  localparam logic [2:0] KIND_QFREE   = 3'd5;
  localparam logic [2:0] KIND_STOPALL = 3'd6;

  // Result codes carried on out_tuser
  localparam logic [3:0] ST_STARTED     = 4'd0;
  localparam logic [3:0] ST_RESTARTED   = 4'd1;
  localparam logic [3:0] ST_ALREADY     = 4'd2;
  localparam logic [3:0] ST_NO_SLOT     = 4'd3;
  localparam logic [3:0] ST_BLOCKED     = 4'd4;
  localparam logic [3:0] ST_STOPPED     = 4'd5;
  localparam logic [3:0] ST_NOT_RUNNING = 4'd6;
  localparam logic [3:0] ST_GRANTED     = 4'd7;
  localparam logic [3:0] ST_LAMP_BUSY   = 4'd8;
  localparam logic [3:0] ST_DONE        = 4'd9;

  // Request broadcast to every slot cell
  typedef struct packed {
    logic [7:0]  effect_id;
    logic [7:0]  prio;
    logic [63:0] mask;
  } cmd_t;

  // Per-cell status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic hit_first;
    logic block;
    logic weaker;
  } cell_flags_t;

  // Per-cell update strobes
  typedef struct packed {
    logic close;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/pla_cell.sv
// One effect slot of the allocator chain: holds effect, priority and lamps.
module pla_cell import pla_pkg::*; #(
  parameter int LAMPS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  cell_ctl_t        ctl,
  input  logic             hit_in,
  input  logic [LAMPS-1:0] rel_in,
  output logic             hit_out,
  output logic [LAMPS-1:0] rel_out,
  output cell_flags_t      flags
);

  logic             busy_r;
  logic [7:0]       effect_r;
  logic [7:0]       prio_r;
  logic [LAMPS-1:0] lamps_r;
  logic             match;
  logic             overlap;

  // Compare against the broadcast request
  assign match   = busy_r && (effect_r == cmd.effect_id);
  assign overlap = busy_r && ((lamps_r & cmd.mask[LAMPS-1:0]) != '0);

  // Pass the lookup carry and released lamps to the next cell
  assign hit_out = hit_in | match;
  assign rel_out = rel_in | (ctl.close ? lamps_r : '0);

  always_comb begin
    flags.busy      = busy_r;
    flags.hit_first = match && !hit_in;
    flags.block     = overlap && (prio_r >= cmd.prio);
    flags.weaker    = overlap && (prio_r < cmd.prio);
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.load) begin
      busy_r <= 1'b1;
    end else if (ctl.close) begin
      busy_r <= 1'b0;
    end
  end

  // Slot contents, only read while occupied
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      effect_r <= cmd.effect_id;
      prio_r   <= cmd.prio;
      lamps_r  <= cmd.mask[LAMPS-1:0];
    end
  end

endmodule

// File: rtl/pla_pick.sv
// Round-robin free-slot search from a rotating start pointer.
module pla_pick #(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS-1:0]                           busy,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ptr,
  output logic                                       avail,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx_inc
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [2*SLOTS-1:0] dbl;
  logic [2*SLOTS-1:0] shifted;
  logic [SLOTS-1:0]   rot;
  logic [SW-1:0]      off;
  logic [SW:0]        sum;

  // Rotate the free vector so the pointer sits at bit zero
  assign dbl     = {~busy, ~busy};
  assign shifted = dbl >> ptr;
  assign rot     = shifted[SLOTS-1:0];
  assign avail   = |rot;

  // Lowest free position at or after the pointer
  always_comb begin
    off = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rot[i]) begin
        off = SW'(i);
      end
    end
  end

  // Wrap back to a slot number and step past it
  always_comb begin
    sum = {1'b0, ptr} + {1'b0, off};
    if (sum >= (SW + 1)'(SLOTS)) begin
      sum = sum - (SW + 1)'(SLOTS);
    end
    idx     = sum[SW-1:0];
    idx_inc = (idx == SW'(SLOTS - 1)) ? '0 : idx + SW'(1);
  end

endmodule

// File: rtl/priority_lamp_effect_allocator_unit.sv
// Top level of the priority lamp effect allocator: sequencer, slot chain and result register.
//
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready   | tuser: kind; tdata: request fields
// out_    | master    | out_tvalid / out_tready | tuser: status; tdata: result fields
//
// An item goes through the accept edge, an evaluation state in which every
// slot cell compares against the request in parallel, and a commit state.
// The commit waits while the result register still holds an untaken result.
// Synchronous active-low reset empties every slot, frees every lamp, zeroes the pointer.
// in_tready is high only while no item is in evaluation or commit.
module priority_lamp_effect_allocator_unit import pla_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int LAMPS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] kind
  input  logic [2:0]  in_tuser,
  // [7:0] effect_id, [15:8] priority_req, [79:16] lamp_mask,
  // [85:80] lamp_number, [88:86] slot_index, [95:89] zero
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] status
  output logic [3:0]  out_tuser,
  // [2:0] slot_used, [10:3] killed_slots, [74:11] free_lamps_now, [79:75] zero
  output logic [79:0] out_tdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [LAMPS-1:0] LAMP_ALL = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } state_t;

  state_t           state_r;
  logic [2:0]       kind_r;
  cmd_t             cmd_r;
  logic [5:0]       lamp_r;
  logic [2:0]       sidx_r;
  logic [LAMPS-1:0] free_r;
  logic [SW-1:0]    next_r;

  // Decision registers, filled in evaluation
  logic [3:0]       status_r,  status_nxt;
  logic [2:0]       slot3_r,   slot3_nxt;
  logic [SLOTS-1:0] kill_r,    kill_nxt;
  logic             load_r,    load_nxt;
  logic [SW-1:0]    grant_r;
  logic [LAMPS-1:0] clr_r,     clr_nxt;
  logic [LAMPS-1:0] set_r,     set_nxt;
  logic             all_r,     all_nxt;
  logic             nwe_r,     nwe_nxt;
  logic [SW-1:0]    nslot_r;

  logic             out_tvalid_r;
  logic [3:0]       out_tuser_r;
  logic [79:0]      out_tdata_r;

  // Cell chain
  cmd_t             cmd_in;
  cell_flags_t      flags [SLOTS];
  cell_ctl_t        ctl   [SLOTS];
  logic [SLOTS:0]   hit_chain;
  logic [LAMPS-1:0] rel_chain [SLOTS+1];
  logic [SLOTS-1:0] busy_v, hit_v, block_v, weaker_v, load_v;

  logic             avail;
  logic [SW-1:0]    pick_idx, pick_inc;
  logic [SW-1:0]    found_idx;
  logic             found;
  logic [LAMPS-1:0] mask_l;
  logic [LAMPS-1:0] lamp_bit;
  logic [SLOTS-1:0] exit_sel;
  logic             lamp_ok;
  logic [SW+2:0]    found_x, pick_x;
  logic [LAMPS+63:0] in_mask_x;
  logic [LAMPS+63:0] free_x;
  logic [SLOTS+7:0] kill_x;
  logic [LAMPS-1:0] free_commit;
  logic             commit;

  // Unpack the request and drop lamp bits beyond the table
  assign in_mask_x        = {64'b0, in_tdata[16 +: LAMPS]};
  assign cmd_in.effect_id = in_tdata[7:0];
  assign cmd_in.prio      = in_tdata[15:8];
  assign cmd_in.mask      = in_mask_x[63:0];

  assign hit_chain[0] = 1'b0;
  assign rel_chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign ctl[i].close = (state_r == S_COMMIT) && commit && kill_r[i];
    assign ctl[i].load  = (state_r == S_COMMIT) && commit && load_r && (grant_r == SW'(i));
    assign busy_v[i]    = flags[i].busy;
    assign hit_v[i]     = flags[i].hit_first;
    assign block_v[i]   = flags[i].block;
    assign weaker_v[i]  = flags[i].weaker;
    assign load_v[i]    = ctl[i].load;

    pla_cell #(.LAMPS(LAMPS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .ctl     (ctl[i]),
      .hit_in  (hit_chain[i]),
      .rel_in  (rel_chain[i]),
      .hit_out (hit_chain[i+1]),
      .rel_out (rel_chain[i+1]),
      .flags   (flags[i])
    );
  end

  pla_pick #(.SLOTS(SLOTS)) u_pick (
    .busy    (busy_v),
    .ptr     (next_r),
    .avail   (avail),
    .idx     (pick_idx),
    .idx_inc (pick_inc)
  );

  // Encode the running slot that matched
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_v[i]) begin
        found_idx = found_idx | SW'(i);
      end
    end
  end

  assign found    = hit_chain[SLOTS];
  assign mask_l   = cmd_r.mask[LAMPS-1:0];
  assign lamp_ok  = {1'b0, lamp_r} < 7'(LAMPS);
  assign lamp_bit = {{(LAMPS-1){1'b0}}, 1'b1} << lamp_r;
  assign exit_sel = {{(SLOTS-1){1'b0}}, 1'b1} << sidx_r;
  assign found_x  = {3'b0, found_idx};
  assign pick_x   = {3'b0, pick_idx};

  // Decide the item's outcome
  always_comb begin
    status_nxt = ST_DONE;
    slot3_nxt  = 3'd0;
    kill_nxt   = '0;
    load_nxt   = 1'b0;
    clr_nxt    = '0;
    set_nxt    = '0;
    all_nxt    = 1'b0;
    nwe_nxt    = 1'b0;
    case (kind_r)
      KIND_START, KIND_RESTART: begin
        if (found) begin
          status_nxt = (kind_r == KIND_START) ? ST_ALREADY : ST_RESTARTED;
          slot3_nxt  = found_x[2:0];
        end else if (!avail) begin
          status_nxt = ST_NO_SLOT;
        end else begin
          nwe_nxt = 1'b1;
          if (((free_r & mask_l) != mask_l) && (block_v != '0)) begin
            status_nxt = ST_BLOCKED;
          end else begin
            if ((free_r & mask_l) != mask_l) begin
              kill_nxt = weaker_v;
            end
            status_nxt = ST_STARTED;
            slot3_nxt  = pick_x[2:0];
            load_nxt   = 1'b1;
            clr_nxt    = mask_l;
          end
        end
      end
      KIND_STOP: begin
        if (found) begin
          status_nxt = ST_STOPPED;
          slot3_nxt  = found_x[2:0];
          kill_nxt   = hit_v;
        end else begin
          status_nxt = ST_NOT_RUNNING;
        end
      end
      KIND_EXIT: begin
        if ((exit_sel & busy_v) != '0) begin
          status_nxt = ST_STOPPED;
          slot3_nxt  = sidx_r;
          kill_nxt   = exit_sel;
        end else begin
          status_nxt = ST_NOT_RUNNING;
        end
      end
      KIND_QALLOC: begin
        if (lamp_ok && ((free_r & lamp_bit) != '0)) begin
          status_nxt = ST_GRANTED;
          clr_nxt    = lamp_bit;
        end else begin
          status_nxt = ST_LAMP_BUSY;
        end
      end
      KIND_QFREE: begin
        set_nxt = lamp_bit;
      end
      KIND_STOPALL: begin
        kill_nxt = busy_v;
        all_nxt  = 1'b1;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Free mask after the item, with lamps released by closing cells
  assign free_commit = all_r ? LAMP_ALL : ((free_r | rel_chain[SLOTS] | set_r) & ~clr_r);
  assign free_x      = {64'b0, free_commit};
  assign kill_x      = {8'b0, kill_r};
  assign commit      = !out_tvalid_r || out_tready;

  // Sequencer, allocator state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_r       <= LAMP_ALL;
      next_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && !((state_r == S_COMMIT) && commit)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r  <= in_tuser;
            cmd_r   <= cmd_in;
            lamp_r  <= in_tdata[85:80];
            sidx_r  <= in_tdata[88:86];
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          status_r <= status_nxt;
          slot3_r  <= slot3_nxt;
          kill_r   <= kill_nxt;
          load_r   <= load_nxt;
          grant_r  <= pick_idx;
          clr_r    <= clr_nxt;
          set_r    <= set_nxt;
          all_r    <= all_nxt;
          nwe_r    <= nwe_nxt;
          nslot_r  <= pick_inc;
          state_r  <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit) begin
            free_r <= free_commit;
            if (nwe_r) begin
              next_r <= nslot_r;
            end
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= status_r;
            out_tdata_r  <= {5'b0, free_x[63:0], kill_x[7:0], slot3_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // Only the first matching slot reports a lookup hit
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v))
    else $error("more than one slot reports a first hit");

  // At most one cell loads per commit
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_v))
    else $error("more than one slot loaded in one commit");

  // Only occupied slots are closed
  a_kill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> ((kill_r & ~busy_v) == '0))
    else $error("closing a slot that is not occupied");

  // A committed item always presents its result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && commit) |=> (out_tvalid && state_r == S_IDLE))
    else $error("commit did not present a result");

endmodule

// File: dv/priority_lamp_effect_allocator_unit_tb.sv
// Self-checking testbench for the priority lamp effect allocator: directed and random requests.
`timescale 1ns / 1ps

module priority_lamp_effect_allocator_unit_tb import pla_pkg::*;;

  localparam int SLOTS = 8;
  localparam int LAMPS = 64;
  // Kind code that the block accepts but ignores
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot;
    logic [7:0]  killed;
    logic [63:0] free;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [3:0]  out_tuser;
  logic [79:0] out_tdata;

  // Allocator state as the testbench sees it
  logic        slot_taken [SLOTS];
  logic [7:0]  slot_eff [SLOTS];
  logic [7:0]  slot_prio [SLOTS];
  logic [63:0] slot_mask [SLOTS];
  logic [63:0] lamps_free;
  int          rr_ptr;
  logic [7:0]  killed_now;

  alloc_result_t awaited_allocations [$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  priority_lamp_effect_allocator_unit #(
    .SLOTS(SLOTS),
    .LAMPS(LAMPS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Empty every slot and free every lamp
  function automatic void reset_allocation();
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_eff[i]   = '0;
      slot_prio[i]  = '0;
      slot_mask[i]  = '0;
    end
    lamps_free = '1;
    rr_ptr     = 0;
  endfunction

  function automatic int find_running(logic [7:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_taken[i] && slot_eff[i] == id) return i;
    return -1;
  endfunction

  // End the effect in slot i and give its lamps back
  function automatic void release_slot(int i);
    lamps_free   |= slot_mask[i];
    slot_taken[i] = 1'b0;
    slot_eff[i]   = '0;
    slot_prio[i]  = '0;
    slot_mask[i]  = '0;
    killed_now[i] = 1'b1;
  endfunction

  function automatic logic [3:0] start_effect(logic [7:0] id, logic [7:0] prio,
                                              logic [63:0] mask, output logic [2:0] slot);
    int hit;
    int grab;
    int idx;
    slot = '0;
    hit  = find_running(id);
    if (hit >= 0) begin
      slot = hit[2:0];
      return ST_ALREADY;
    end
    // Round-robin search for an empty slot from the rotating pointer
    grab = -1;
    for (int n = 0; n < SLOTS; n++) begin
      idx = (rr_ptr + n) % SLOTS;
      if (!slot_taken[idx]) begin
        grab = idx;
        break;
      end
    end
    if (grab < 0) return ST_NO_SLOT;
    rr_ptr = (grab + 1) % SLOTS;
    // Preempt weaker overlapping holders, or give up on one of equal or higher priority
    if ((lamps_free & mask) != mask) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_taken[i] && (slot_mask[i] & mask) != '0 && slot_prio[i] >= prio)
          return ST_BLOCKED;
      for (int i = 0; i < SLOTS; i++)
        if (slot_taken[i] && (slot_mask[i] & mask) != '0 && slot_prio[i] < prio)
          release_slot(i);
    end
    lamps_free      &= ~mask;
    slot_taken[grab] = 1'b1;
    slot_eff[grab]   = id;
    slot_prio[grab]  = prio;
    slot_mask[grab]  = mask;
    slot = grab[2:0];
    return ST_STARTED;
  endfunction

  // Apply one request to the tracked state and return the reply it should give
  function automatic alloc_result_t compute_allocation(logic [2:0] kind, logic [7:0] id,
                                                       logic [7:0] prio, logic [63:0] mask,
                                                       logic [5:0] lamp, logic [2:0] sidx);
    alloc_result_t r;
    int hit;
    killed_now = '0;
    r.slot     = '0;
    r.status   = ST_DONE;
    case (kind)
      KIND_START: begin
        r.status = start_effect(id, prio, mask, r.slot);
      end
      KIND_STOP: begin
        hit = find_running(id);
        if (hit < 0) begin
          r.status = ST_NOT_RUNNING;
        end else begin
          release_slot(hit);
          r.slot   = hit[2:0];
          r.status = ST_STOPPED;
        end
      end
      KIND_RESTART: begin
        hit = find_running(id);
        if (hit < 0) begin
          r.status = start_effect(id, prio, mask, r.slot);
        end else begin
          r.slot   = hit[2:0];
          r.status = ST_RESTARTED;
        end
      end
      KIND_EXIT: begin
        if (slot_taken[sidx]) begin
          release_slot(sidx);
          r.slot   = sidx;
          r.status = ST_STOPPED;
        end else begin
          r.status = ST_NOT_RUNNING;
        end
      end
      KIND_QALLOC: begin
        if (lamps_free[lamp]) begin
          lamps_free[lamp] = 1'b0;
          r.status = ST_GRANTED;
        end else begin
          r.status = ST_LAMP_BUSY;
        end
      end
      KIND_QFREE: begin
        lamps_free[lamp] = 1'b1;
      end
      KIND_STOPALL: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_taken[i]) release_slot(i);
        lamps_free = '1;
      end
      default: begin
        r.status = ST_DONE;
      end
    endcase
    r.killed = killed_now;
    r.free   = lamps_free;
    return r;
  endfunction

  // Offer one request, hold it until taken, then log the reply it should give
  task automatic send_request(logic [2:0] kind, logic [7:0] id, logic [7:0] prio,
                              logic [63:0] mask, logic [5:0] lamp, logic [2:0] sidx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, sidx, lamp, mask, prio, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_allocations.push_back(compute_allocation(kind, id, prio, mask, lamp, sidx));
  endtask

  // Stop offering and wait for every outstanding reply
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (awaited_allocations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void report_field(string field, logic [63:0] want, logic [63:0] seen);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, seen);
    mismatches++;
  endfunction

  // Compare each reply transaction with the oldest expectation
  always @(posedge clk) begin : reply_check
    alloc_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (awaited_allocations.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual status 0x%0h data 0x%0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = awaited_allocations.pop_front();
        if (out_tuser !== want.status) report_field("status", want.status, out_tuser);
        if (out_tdata[2:0] !== want.slot) report_field("slot_used", want.slot, out_tdata[2:0]);
        if (out_tdata[10:3] !== want.killed)
          report_field("killed_slots", want.killed, out_tdata[10:3]);
        if (out_tdata[74:11] !== want.free)
          report_field("free_lamps_now", want.free, out_tdata[74:11]);
      end
    end
  end

  task automatic test_directed();
    tx_idle_pct = 33;
    rx_idle_pct = 62;
    // Fresh start, duplicate start, restart of a running effect
    send_request(KIND_START, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_START, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_RESTART, 8'd0, 8'd9, 64'hFF, 6'd0, 3'd0);
    // Restart of an idle effect acts as a start, claiming every lamp
    send_request(KIND_RESTART, 8'd255, 8'd255, '1, 6'd63, 3'd7);
    // Equal priority overlap blocks, pointer still moves on
    send_request(KIND_START, 8'd1, 8'd255, 64'd1, 6'd0, 3'd0);
    send_request(KIND_QALLOC, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_STOP, 8'd255, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_STOP, 8'd255, 8'd0, 64'd0, 6'd0, 3'd0);
    // Single lamp granted, then refused
    send_request(KIND_QALLOC, 8'd0, 8'd0, 64'd0, 6'd63, 3'd0);
    send_request(KIND_QALLOC, 8'd0, 8'd0, 64'd0, 6'd63, 3'd0);
    // Lamp held by a quick alloc is claimed anyway, then a stronger effect preempts
    send_request(KIND_START, 8'd2, 8'd10, 64'h8000_0000_0000_0020, 6'd0, 3'd0);
    send_request(KIND_START, 8'd3, 8'd20, 64'h20, 6'd0, 3'd0);
    send_request(KIND_QFREE, 8'd0, 8'd0, 64'd0, 6'd63, 3'd0);
    send_request(KIND_QFREE, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_EXIT, 8'd0, 8'd0, 64'd0, 6'd0, 3'd7);
    // Fill the table until a start finds no slot
    for (int k = 0; k < 7; k++)
      send_request(KIND_START, 8'(20 + k), 8'd5, 64'd0, 6'd0, 3'd0);
    send_request(KIND_EXIT, 8'd0, 8'd0, 64'd0, 6'd0, 3'd7);
    send_request(KIND_UNUSED, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    send_request(KIND_STOPALL, 8'd0, 8'd0, 64'd0, 6'd0, 3'd0);
    drain_replies();
  endtask

  task automatic test_random(int count, int tx_pct, int rx_pct);
    int sent;
    int pick;
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [63:0] mask;
    logic [5:0]  lamp;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35)      kind = KIND_START;
      else if (pick < 47) kind = KIND_RESTART;
      else if (pick < 60) kind = KIND_STOP;
      else if (pick < 70) kind = KIND_EXIT;
      else if (pick < 82) kind = KIND_QALLOC;
      else if (pick < 94) kind = KIND_QFREE;
      else if (pick < 97) kind = KIND_STOPALL;
      else                kind = KIND_UNUSED;
      // Mostly a small pool of effects so that stops and restarts find them
      id = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(11));
      pick = $urandom_range(9);
      if (pick == 0) begin
        mask = {$urandom, $urandom};
      end else if (pick == 1) begin
        mask = '0;
      end else if (pick == 2) begin
        mask = '1;
      end else begin
        // Sparse masks, often in the low lamps to provoke overlap
        mask = '0;
        repeat ($urandom_range(1, 3))
          mask[$urandom_range($urandom_range(1) ? 15 : 63)] = 1'b1;
      end
      lamp = $urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
      send_request(kind, id, 8'($urandom_range(255)), mask, lamp, 3'($urandom_range(7)));
      if (kind != KIND_UNUSED) sent++;
    end
    drain_replies();
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = 200;
    for (int k = 0; k < 20; k++)
      send_request(k % 3 == 0 ? KIND_QALLOC : KIND_START, 8'($urandom_range(15)),
                   8'($urandom_range(255)), 64'(1) << $urandom_range(63),
                   6'($urandom_range(63)), 3'($urandom_range(7)));
    drain_replies();
  endtask

  initial begin
    reset_allocation();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(210, 33, 62);
    test_random(210, 62, 33);
    test_backpressure();
    test_random(210, 0, 0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/pla_pkg.sv
rtl/pla_cell.sv
rtl/pla_pick.sv
rtl/priority_lamp_effect_allocator_unit.sv
dv/priority_lamp_effect_allocator_unit_tb.sv
